@@ design/rhsv_pkg.sv @@
// Package for the RGB to HSV converter: widths, sector codes and pipeline stage types.
`default_nettype none

package rhsv_pkg;

    localparam int CHAN_W     = 8;
    localparam int PIX_W      = 3 * CHAN_W;
    localparam int QUOT_W     = 8;
    localparam int SAT_REM_W  = 16;   // 255 * delta fits below 2^16
    localparam int HUE_NUM_W  = 11;   // sector numerator stays below 6 * delta <= 1530
    localparam int HUE_REM_W  = 19;   // 255 * numerator fits below 2^19
    localparam int HUE_DIV_W  = 11;   // 6 * delta
    localparam int SNUM_W     = 13;   // signed working width of the numerator
    localparam int DIV_STAGES = QUOT_W;
    localparam int NUM_STAGES = DIV_STAGES + 3;

    typedef enum logic [1:0] {
        SECT_RED,
        SECT_GREEN,
        SECT_BLUE
    } sector_t;

    // Extremes and sector of the pixel
    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] vmax;
        logic [CHAN_W-1:0] vmin;
        sector_t           sector;
    } ext_stage_t;

    // Delta and wrapped hue numerator
    typedef struct packed {
        logic [CHAN_W-1:0]    vmax;
        logic [CHAN_W-1:0]    delta;
        logic [HUE_NUM_W-1:0] num;
    } num_stage_t;

    // One step of the two restoring dividers
    typedef struct packed {
        logic                 grey;
        logic [CHAN_W-1:0]    vmax;
        logic [SAT_REM_W-1:0] sat_rem;
        logic [CHAN_W-1:0]    sat_div;
        logic [QUOT_W-1:0]    sat_quot;
        logic [HUE_REM_W-1:0] hue_rem;
        logic [HUE_DIV_W-1:0] hue_div;
        logic [QUOT_W-1:0]    hue_quot;
    } div_stage_t;

endpackage

`default_nettype wire

@@ design/rgb_to_hsv_converter.sv @@
// RGB to HSV converter: pipelined extremes, numerator and two restoring dividers.
`default_nettype none

// Converts one 8-bit RGB pixel per clock into 8-bit hue, saturation and value. Each item
// passes through 11 register stages in order: one stage for maximum, minimum and sector,
// one for delta and the hue numerator, one to form the scaled dividends and divisors,
// and eight stages of restoring division that each settle one quotient bit of both the
// saturation and the hue quotient. Every stage has its own valid bit and loads whenever
// it is empty or its successor moves, so a new item is taken in every cycle while the
// output is consumed, and bubbles are squeezed out during a stall. Grey pixels (all
// channels equal) give zero hue and saturation. No reset sweep is needed.
module rgb_to_hsv_converter
    import rhsv_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             s_axis_tvalid,
    output logic                  s_axis_tready,
    input  wire logic [PIX_W-1:0] s_axis_tdata,   // red_in, green_in, blue_in
    output logic                  m_axis_tvalid,
    input  wire logic             m_axis_tready,
    output logic [PIX_W-1:0]      m_axis_tdata    // hue_out, saturation_out, value_out
);

    logic [NUM_STAGES-1:0] valid_reg;
    logic [NUM_STAGES-1:0] valid_next;
    logic [NUM_STAGES-1:0] load;

    ext_stage_t ext_reg;
    ext_stage_t ext_next;
    num_stage_t num_reg;
    num_stage_t num_next;
    div_stage_t div_reg  [0:DIV_STAGES];
    div_stage_t div_next [0:DIV_STAGES];

    // Let a stage load when it is empty or its successor takes its item
    always_comb
    begin
        load[NUM_STAGES-1] = !valid_reg[NUM_STAGES-1] || m_axis_tready;
        for (int k = NUM_STAGES - 2; k >= 0; k--)
        begin
            load[k] = !valid_reg[k] || load[k+1];
        end
    end

    // Advance valid bits with the data
    always_comb
    begin
        valid_next[0] = load[0] ? s_axis_tvalid : valid_reg[0];
        for (int k = 1; k < NUM_STAGES; k++)
        begin
            valid_next[k] = load[k] ? valid_reg[k-1] : valid_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Stage one: maximum, minimum and the first maximal channel
    always_comb
    begin
        logic [CHAN_W-1:0] r;
        logic [CHAN_W-1:0] g;
        logic [CHAN_W-1:0] b;
        logic [CHAN_W-1:0] max_rg;
        logic [CHAN_W-1:0] min_rg;
        r      = s_axis_tdata[CHAN_W-1:0];
        g      = s_axis_tdata[2*CHAN_W-1:CHAN_W];
        b      = s_axis_tdata[3*CHAN_W-1:2*CHAN_W];
        max_rg = (r > g) ? r : g;
        min_rg = (r < g) ? r : g;
        ext_next.red   = r;
        ext_next.green = g;
        ext_next.blue  = b;
        ext_next.vmax  = (max_rg > b) ? max_rg : b;
        ext_next.vmin  = (min_rg < b) ? min_rg : b;
        if (r >= g && r >= b)
        begin
            ext_next.sector = SECT_RED;
        end
        else if (g >= b)
        begin
            ext_next.sector = SECT_GREEN;
        end
        else
        begin
            ext_next.sector = SECT_BLUE;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load[0])
        begin
            ext_reg <= ext_next;
        end
    end

    // Stage two: delta and the sector numerator, wrapped into one turn
    always_comb
    begin
        logic [CHAN_W-1:0]        delta;
        logic signed [SNUM_W-1:0] d_s;
        logic signed [SNUM_W-1:0] r_s;
        logic signed [SNUM_W-1:0] g_s;
        logic signed [SNUM_W-1:0] b_s;
        logic signed [SNUM_W-1:0] num_s;
        delta = ext_reg.vmax - ext_reg.vmin;
        d_s   = $signed({{(SNUM_W-CHAN_W){1'b0}}, delta});
        r_s   = $signed({{(SNUM_W-CHAN_W){1'b0}}, ext_reg.red});
        g_s   = $signed({{(SNUM_W-CHAN_W){1'b0}}, ext_reg.green});
        b_s   = $signed({{(SNUM_W-CHAN_W){1'b0}}, ext_reg.blue});
        unique case (ext_reg.sector)
            SECT_RED:   num_s = g_s - b_s;
            SECT_GREEN: num_s = (d_s <<< 1) + b_s - r_s;
            SECT_BLUE:  num_s = (d_s <<< 2) + r_s - g_s;
            default:    num_s = '0;
        endcase
        if (num_s < 0)
        begin
            num_s = num_s + (d_s <<< 2) + (d_s <<< 1);
        end
        num_next.vmax  = ext_reg.vmax;
        num_next.delta = delta;
        num_next.num   = num_s[HUE_NUM_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (load[1])
        begin
            num_reg <= num_next;
        end
    end

    // Stage three: scale the dividends by 255 and form the divisors;
    // divide stages: settle one quotient bit each, highest bit first
    always_comb
    begin
        logic [HUE_DIV_W-1:0] delta_w;
        logic [SAT_REM_W-1:0] sat_trial;
        logic [HUE_REM_W-1:0] hue_trial;
        logic                 sat_ok;
        logic                 hue_ok;
        delta_w = {{(HUE_DIV_W-CHAN_W){1'b0}}, num_reg.delta};
        div_next[0].grey     = (num_reg.delta == '0);
        div_next[0].vmax     = num_reg.vmax;
        div_next[0].sat_rem  = {num_reg.delta, {CHAN_W{1'b0}}}
                               - {{(SAT_REM_W-CHAN_W){1'b0}}, num_reg.delta};
        div_next[0].sat_div  = num_reg.vmax;
        div_next[0].sat_quot = '0;
        div_next[0].hue_rem  = {num_reg.num, {CHAN_W{1'b0}}}
                               - {{(HUE_REM_W-HUE_NUM_W){1'b0}}, num_reg.num};
        div_next[0].hue_div  = (delta_w << 2) + (delta_w << 1);
        div_next[0].hue_quot = '0;
        for (int j = 1; j <= DIV_STAGES; j++)
        begin
            sat_trial = {{(SAT_REM_W-CHAN_W){1'b0}}, div_reg[j-1].sat_div} << (QUOT_W - j);
            hue_trial = {{(HUE_REM_W-HUE_DIV_W){1'b0}}, div_reg[j-1].hue_div} << (QUOT_W - j);
            sat_ok    = !div_reg[j-1].grey && (div_reg[j-1].sat_rem >= sat_trial);
            hue_ok    = !div_reg[j-1].grey && (div_reg[j-1].hue_rem >= hue_trial);
            div_next[j]          = div_reg[j-1];
            div_next[j].sat_rem  = sat_ok ? div_reg[j-1].sat_rem - sat_trial
                                          : div_reg[j-1].sat_rem;
            div_next[j].hue_rem  = hue_ok ? div_reg[j-1].hue_rem - hue_trial
                                          : div_reg[j-1].hue_rem;
            div_next[j].sat_quot = {div_reg[j-1].sat_quot[QUOT_W-2:0], sat_ok};
            div_next[j].hue_quot = {div_reg[j-1].hue_quot[QUOT_W-2:0], hue_ok};
        end
    end

    always_ff @(posedge clk)
    begin
        for (int j = 0; j <= DIV_STAGES; j++)
        begin
            if (load[j+2])
            begin
                div_reg[j] <= div_next[j];
            end
        end
    end

    // Drive the handshake and the result item from the last stage
    assign s_axis_tready = load[0];
    assign m_axis_tvalid = valid_reg[NUM_STAGES-1];
    assign m_axis_tdata  = {div_reg[DIV_STAGES].vmax,
                            div_reg[DIV_STAGES].sat_quot,
                            div_reg[DIV_STAGES].hue_quot};

`ifndef SYNTHESIS
    // Input is refused only when the whole pipeline is full and the output is stalled
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
        else $error("input stalled while pipeline has room");

    // Zero saturation means a grey pixel, whose hue is zero
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tdata[2*CHAN_W-1:CHAN_W] == '0)
        |-> (m_axis_tdata[CHAN_W-1:0] == '0))
        else $error("grey item with non-zero hue");

    // Black pixel gives zero saturation
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tdata[3*CHAN_W-1:2*CHAN_W] == '0)
        |-> (m_axis_tdata[2*CHAN_W-1:CHAN_W] == '0))
        else $error("black item with non-zero saturation");

    // Hue never reaches a full turn
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[CHAN_W-1:0] != {CHAN_W{1'b1}}))
        else $error("hue quotient overflow");
`endif

endmodule

`default_nettype wire
